>>> rtl/grid_window_neighbor_lister_top_assert.svh
// Assertion macros shared by the lister modules.
// Each macro expects clk and rst_n in scope.
`ifndef GRID_WINDOW_NEIGHBOR_LISTER_TOP_ASSERT_SVH
`define GRID_WINDOW_NEIGHBOR_LISTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define GWNL_AST_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GWNL_AST_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gwnl_pkg.sv
`default_nettype none
package gwnl_pkg;

  // Field and register widths
  localparam int CELL_W     = 20;
  localparam int SIDE_W     = 11;
  localparam int REACH_W    = 2;
  localparam int IBASE_W    = 24;
  localparam int EBASE_W    = 26;
  localparam int NB_W       = 25;
  localparam int FE_W       = 27;
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 26;

  localparam logic [FE_W-1:0] EDGE_MAX = {FE_W{1'b1}};

  // Default build limits
  localparam int DEF_MAX_SIDE  = 1024;
  localparam int DEF_MAX_REACH = 3;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] CFG_GRID_SIDE  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_REACH      = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_INDEX_BASE = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_EDGE_BASE  = 2'd3;

  // Register reset values
  localparam logic [SIDE_W-1:0]  RST_GRID_SIDE = 11'd1;
  localparam logic [REACH_W-1:0] RST_REACH     = 2'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV,
    ST_SETUP,
    ST_BASE,
    ST_WALK,
    ST_FLAG
  } st_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic check;
    logic div_step;
    logic setup;
    logic base;
    logic advance;
    logic emit;
    logic flag;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic lonely;
    logic div_done;
    logic out_free;
    logic self_pos;
    logic at_end;
  } dp_stat_t;

endpackage
`default_nettype wire

>>> rtl/gwnl_if.sv
`default_nettype none
// Cell index channel
interface gwnl_in_if;
  logic                         valid;
  logic                         ready;
  logic [gwnl_pkg::CELL_W-1:0]  cell_index;

  modport source (output valid, output cell_index, input ready);
  modport sink   (input valid, input cell_index, output ready);
endinterface

// Neighbor result channel
interface gwnl_out_if;
  logic                         valid;
  logic                         ready;
  logic [gwnl_pkg::NB_W-1:0]    neighbor_index;
  logic [gwnl_pkg::FE_W-1:0]    first_edge;
  logic                         last;
  logic                         no_neighbor;
  logic                         bad_cell;

  modport source (output valid, output neighbor_index, output first_edge, output last,
                  output no_neighbor, output bad_cell, input ready);
  modport sink   (input valid, input neighbor_index, input first_edge, input last,
                  input no_neighbor, input bad_cell, output ready);
endinterface
`default_nettype wire

>>> rtl/gwnl_ctrl.sv
`default_nettype none
`include "grid_window_neighbor_lister_top_assert.svh"
module gwnl_ctrl (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire gwnl_pkg::dp_stat_t stat,
  output gwnl_pkg::ctl_cmd_t      cmd
);

  gwnl_pkg::st_t state_r;
  gwnl_pkg::st_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= gwnl_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      gwnl_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = gwnl_pkg::ST_CHECK;
      end
      gwnl_pkg::ST_CHECK: begin
        if (stat.bad || stat.lonely) state_nxt = gwnl_pkg::ST_FLAG;
        else                         state_nxt = gwnl_pkg::ST_DIV;
      end
      gwnl_pkg::ST_DIV: begin
        if (stat.div_done) state_nxt = gwnl_pkg::ST_SETUP;
      end
      gwnl_pkg::ST_SETUP: begin
        state_nxt = gwnl_pkg::ST_BASE;
      end
      gwnl_pkg::ST_BASE: begin
        state_nxt = gwnl_pkg::ST_WALK;
      end
      gwnl_pkg::ST_WALK: begin
        if ((stat.self_pos || stat.out_free) && stat.at_end) state_nxt = gwnl_pkg::ST_IDLE;
      end
      gwnl_pkg::ST_FLAG: begin
        if (stat.out_free) state_nxt = gwnl_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = gwnl_pkg::ST_IDLE;
      end
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      gwnl_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      gwnl_pkg::ST_CHECK: begin
        cmd.check = 1'b1;
      end
      gwnl_pkg::ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      gwnl_pkg::ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      gwnl_pkg::ST_BASE: begin
        cmd.base = 1'b1;
      end
      gwnl_pkg::ST_WALK: begin
        // skip the cell itself without a beat
        cmd.advance = stat.self_pos || stat.out_free;
        cmd.emit    = !stat.self_pos && stat.out_free;
      end
      gwnl_pkg::ST_FLAG: begin
        cmd.flag = stat.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

  `GWNL_AST_IMP(a_emit_free, cmd.emit || cmd.flag, stat.out_free, "beat loaded while output busy")
  `GWNL_AST_IMP(a_one_cmd, 1'b1,
    $onehot0({cmd.load, cmd.check, cmd.div_step, cmd.setup, cmd.base, cmd.advance, cmd.flag}),
    "more than one datapath command")

endmodule
`default_nettype wire

>>> rtl/gwnl_dp.sv
`default_nettype none
`include "grid_window_neighbor_lister_top_assert.svh"
module gwnl_dp #(
  parameter int MAX_SIDE  = gwnl_pkg::DEF_MAX_SIDE,
  parameter int MAX_REACH = gwnl_pkg::DEF_MAX_REACH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gwnl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [gwnl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  input  wire logic [gwnl_pkg::CELL_W-1:0]      in_cell,
  input  wire gwnl_pkg::ctl_cmd_t               cmd,
  output gwnl_pkg::dp_stat_t                    stat,
  output logic                                  out_valid,
  input  wire logic                             out_ready,
  output logic [gwnl_pkg::NB_W-1:0]             out_nb,
  output logic [gwnl_pkg::FE_W-1:0]             out_fe,
  output logic                                  out_last,
  output logic                                  out_none,
  output logic                                  out_bad
);

  localparam int CELL_W  = gwnl_pkg::CELL_W;
  localparam int SIDE_W  = gwnl_pkg::SIDE_W;
  localparam int REACH_W = gwnl_pkg::REACH_W;
  localparam int NB_W    = gwnl_pkg::NB_W;
  localparam int FE_W    = gwnl_pkg::FE_W;
  localparam int SQ_W    = 2 * SIDE_W;
  localparam int DCNT_W  = $clog2(CELL_W);
  localparam int WIN_W   = $clog2(2 * MAX_REACH + 2);
  localparam int PROD_W  = 2 * WIN_W;
  localparam int CNT_W   = $clog2((2 * MAX_REACH + 1) * (2 * MAX_REACH + 1));
  localparam int SIDE_TOP = (1 << SIDE_W) - 1;
  localparam int SIDE_CAP = (MAX_SIDE > SIDE_TOP) ? SIDE_TOP : MAX_SIDE;

  // Configuration registers
  logic [SIDE_W-1:0]              grid_side_r;
  logic [REACH_W-1:0]             reach_r;
  logic [gwnl_pkg::IBASE_W-1:0]   index_base_r;
  logic [gwnl_pkg::EBASE_W-1:0]   edge_base_r;
  logic [FE_W-1:0]                edge_count_r;

  // Item state
  logic [CELL_W-1:0]  cell_r;
  logic [SIDE_W-1:0]  side_r;
  logic [REACH_W-1:0] r_r;
  logic [FE_W-1:0]    fe_r;
  logic               bad_r;
  logic               lonely_r;
  logic [CELL_W-1:0]  quo_r;
  logic [SIDE_W-1:0]  rem_r;
  logic [DCNT_W-1:0]  dcnt_r;
  logic [SIDE_W-1:0]  x0_r;
  logic [SIDE_W-1:0]  xlast_r;
  logic [SIDE_W-1:0]  ylast_r;
  logic [SIDE_W-1:0]  x_r;
  logic [SIDE_W-1:0]  y_r;
  logic [NB_W-1:0]    base_r;
  logic [CNT_W-1:0]   nlast_r;
  logic [CNT_W-1:0]   ecnt_r;

  // Output register
  logic               out_valid_r;
  logic [NB_W-1:0]    out_nb_r;
  logic [FE_W-1:0]    out_fe_r;
  logic               out_last_r;
  logic               out_none_r;
  logic               out_bad_r;

  logic [SIDE_W-1:0]  side_eff;
  logic [REACH_W-1:0] reach_eff;
  logic [FE_W:0]      fe_sum;
  logic [FE_W-1:0]    fe_calc;
  logic [SQ_W-1:0]    sq;
  logic               bad_c;
  logic               lonely_c;
  logic [SIDE_W:0]    rem_sh;
  logic               ge;
  logic [SIDE_W-1:0]  col;
  logic [SIDE_W-1:0]  row;
  logic [SIDE_W-1:0]  rz;
  logic [SIDE_W:0]    xhi;
  logic [SIDE_W:0]    yhi;
  logic [SIDE_W-1:0]  x0_c;
  logic [SIDE_W-1:0]  y0_c;
  logic [SIDE_W-1:0]  xlast_c;
  logic [SIDE_W-1:0]  ylast_c;
  logic [SQ_W-1:0]    yprod;
  logic [WIN_W-1:0]   wcols;
  logic [WIN_W-1:0]   hrows;
  logic [PROD_W-1:0]  wprod;
  logic               out_free;

  // Clip limits and first edge position
  assign side_eff  = (grid_side_r > SIDE_W'(SIDE_CAP)) ? SIDE_W'(SIDE_CAP) : grid_side_r;
  assign reach_eff = (reach_r > REACH_W'(MAX_REACH)) ? REACH_W'(MAX_REACH) : reach_r;
  assign fe_sum    = (FE_W + 1)'(edge_base_r) + (FE_W + 1)'(edge_count_r);
  assign fe_calc   = (fe_sum > (FE_W + 1)'(gwnl_pkg::EDGE_MAX)) ? gwnl_pkg::EDGE_MAX
                                                                : fe_sum[FE_W-1:0];

  // Range check
  assign sq       = side_r * side_r;
  assign bad_c    = (side_r == '0) || (SQ_W'(cell_r) >= sq);
  assign lonely_c = !bad_c && ((r_r == '0) || (side_r == SIDE_W'(1)));

  // One quotient bit per step
  assign rem_sh = {rem_r, quo_r[CELL_W-1]};
  assign ge     = rem_sh >= {1'b0, side_r};

  // Window bounds
  assign col     = rem_r;
  assign row     = quo_r[SIDE_W-1:0];
  assign rz      = SIDE_W'(r_r);
  assign x0_c    = (col > rz) ? col - rz : '0;
  assign y0_c    = (row > rz) ? row - rz : '0;
  assign xhi     = {1'b0, col} + {1'b0, rz};
  assign yhi     = {1'b0, row} + {1'b0, rz};
  assign xlast_c = (xhi < {1'b0, side_r}) ? xhi[SIDE_W-1:0] : side_r - SIDE_W'(1);
  assign ylast_c = (yhi < {1'b0, side_r}) ? yhi[SIDE_W-1:0] : side_r - SIDE_W'(1);

  // Row start and neighbor count
  assign yprod = y_r * side_r;
  assign wcols = WIN_W'(xlast_r - x0_r) + WIN_W'(1);
  assign hrows = WIN_W'(ylast_r - y_r) + WIN_W'(1);
  assign wprod = PROD_W'(wcols) * PROD_W'(hrows);

  assign out_free = !out_valid_r || out_ready;

  assign stat.bad      = bad_c;
  assign stat.lonely   = lonely_c;
  assign stat.div_done = (dcnt_r == DCNT_W'(CELL_W - 1));
  assign stat.out_free = out_free;
  assign stat.self_pos = (x_r == col) && (y_r == row);
  assign stat.at_end   = (x_r == xlast_r) && (y_r == ylast_r);

  // Configuration and running edge count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_side_r  <= gwnl_pkg::RST_GRID_SIDE;
      reach_r      <= gwnl_pkg::RST_REACH;
      index_base_r <= '0;
      edge_base_r  <= '0;
      edge_count_r <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_addr)
          gwnl_pkg::CFG_GRID_SIDE:  grid_side_r  <= cfg_wdata[SIDE_W-1:0];
          gwnl_pkg::CFG_REACH:      reach_r      <= cfg_wdata[REACH_W-1:0];
          gwnl_pkg::CFG_INDEX_BASE: index_base_r <= cfg_wdata[gwnl_pkg::IBASE_W-1:0];
          gwnl_pkg::CFG_EDGE_BASE:  edge_base_r  <= cfg_wdata[gwnl_pkg::EBASE_W-1:0];
          default: ;
        endcase
      end
      if (cmd.emit && (edge_count_r != gwnl_pkg::EDGE_MAX)) begin
        edge_count_r <= edge_count_r + FE_W'(1);
      end
    end
  end

  // Item datapath
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_r <= in_cell;
      side_r <= side_eff;
      r_r    <= reach_eff;
      fe_r   <= fe_calc;
    end
    if (cmd.check) begin
      bad_r    <= bad_c;
      lonely_r <= lonely_c;
      quo_r    <= cell_r;
      rem_r    <= '0;
      dcnt_r   <= '0;
    end
    if (cmd.div_step) begin
      rem_r  <= ge ? SIDE_W'(rem_sh - {1'b0, side_r}) : rem_sh[SIDE_W-1:0];
      quo_r  <= {quo_r[CELL_W-2:0], ge};
      dcnt_r <= dcnt_r + DCNT_W'(1);
    end
    if (cmd.setup) begin
      x0_r    <= x0_c;
      x_r     <= x0_c;
      y_r     <= y0_c;
      xlast_r <= xlast_c;
      ylast_r <= ylast_c;
    end
    if (cmd.base) begin
      base_r  <= NB_W'(index_base_r) + NB_W'(yprod);
      nlast_r <= CNT_W'(wprod - PROD_W'(2));
      ecnt_r  <= '0;
    end
    // advance row-major through the window
    if (cmd.advance) begin
      if (x_r == xlast_r) begin
        x_r    <= x0_r;
        y_r    <= y_r + SIDE_W'(1);
        base_r <= base_r + NB_W'(side_r);
      end else begin
        x_r <= x_r + SIDE_W'(1);
      end
    end
    if (cmd.emit) begin
      ecnt_r <= ecnt_r + CNT_W'(1);
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit || cmd.flag) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_nb_r   <= base_r + NB_W'(x_r);
      out_fe_r   <= fe_r;
      out_last_r <= (ecnt_r == nlast_r);
      out_none_r <= 1'b0;
      out_bad_r  <= 1'b0;
    end else if (cmd.flag) begin
      out_nb_r   <= '0;
      out_fe_r   <= fe_r;
      out_last_r <= 1'b1;
      out_none_r <= lonely_r;
      out_bad_r  <= bad_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_nb    = out_nb_r;
  assign out_fe    = out_fe_r;
  assign out_last  = out_last_r;
  assign out_none  = out_none_r;
  assign out_bad   = out_bad_r;

  `GWNL_AST_IMP(a_edge_mono, $past(rst_n), edge_count_r >= $past(edge_count_r),
    "edge count moved backward")
  `GWNL_AST_IMP(a_flag_shape, out_valid_r && (out_bad_r || out_none_r),
    out_last_r && (out_nb_r == '0) && !(out_bad_r && out_none_r), "malformed flagged beat")

endmodule
`default_nettype wire

>>> rtl/grid_window_neighbor_lister_top.sv
`default_nettype none
// A flagged cell (bad index or no neighbors) gets a single flagged beat; otherwise the
// index is split into row and column by a 20-step bit-serial division and the clipped
// window (up to 49 cells) is walked row by row, one window cell per cycle unless a beat
// must wait for the output, the cell itself skipped without a beat. The output register
// lets the next item start while the final beat waits. Reset (rst_n, synchronous) idles
// the controller, clears the edge count and returns the registers to their defaults.
module grid_window_neighbor_lister_top #(
  parameter int MAX_SIDE  = gwnl_pkg::DEF_MAX_SIDE,
  parameter int MAX_REACH = gwnl_pkg::DEF_MAX_REACH
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic                             cfg_we,
  input  wire logic [gwnl_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  wire logic [gwnl_pkg::CFG_DATA_W-1:0]  cfg_wdata,
  gwnl_in_if.sink                               in_ch,
  gwnl_out_if.source                            out_ch
);

  gwnl_pkg::ctl_cmd_t cmd;
  gwnl_pkg::dp_stat_t stat;
  logic               in_ready;

  gwnl_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  gwnl_dp #(
    .MAX_SIDE  (MAX_SIDE),
    .MAX_REACH (MAX_REACH)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_cell   (in_ch.cell_index),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_nb    (out_ch.neighbor_index),
    .out_fe    (out_ch.first_edge),
    .out_last  (out_ch.last),
    .out_none  (out_ch.no_neighbor),
    .out_bad   (out_ch.bad_cell)
  );

  assign in_ch.ready = in_ready;

endmodule
`default_nettype wire

>>> tb/gwnl_neighbor_checker.sv
`timescale 1ns / 100ps
// Watches the config port and both channels, predicts the neighbor beats of
// every accepted cell and compares each result beat against the oldest one.
module gwnl_neighbor_checker #(
  parameter int MAX_SIDE  = gwnl_pkg::DEF_MAX_SIDE,
  parameter int MAX_REACH = gwnl_pkg::DEF_MAX_REACH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [gwnl_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [gwnl_pkg::CFG_DATA_W-1:0] cfg_wdata,
  gwnl_in_if                              in_mon,
  gwnl_out_if                             out_mon,
  output int                              mismatch_count,
  output int                              beats_owed
);

  typedef struct {
    logic [gwnl_pkg::NB_W-1:0]   neighbor_index;
    logic [gwnl_pkg::FE_W-1:0]   first_edge;
    logic                        last;
    logic                        no_neighbor;
    logic                        bad_cell;
    logic [gwnl_pkg::CELL_W-1:0] src_cell;
  } nb_beat_t;

  // Shadow copies of the block's registers and edge counter
  logic [gwnl_pkg::SIDE_W-1:0]  side_reg;
  logic [gwnl_pkg::REACH_W-1:0] reach_reg;
  logic [gwnl_pkg::IBASE_W-1:0] ibase_reg;
  logic [gwnl_pkg::EBASE_W-1:0] ebase_reg;
  logic [gwnl_pkg::FE_W-1:0]    edge_total;

  nb_beat_t window_beats[$];

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Append one expected beat at the tail
  function automatic void queue_beat(input nb_beat_t b);
    window_beats.insert(window_beats.size(), b);
  endfunction

  // Walk the clipped window row by row and queue one beat per neighbor, or one flagged beat for a bad or lonely cell
  function automatic void list_window(input logic [gwnl_pkg::CELL_W-1:0] cell_idx);
    int unsigned side, rad, col, row, x0, y0, x1, y1, x, y, idx;
    longint unsigned fe_sum, grown;
    nb_beat_t b;
    nb_beat_t found[$];
    side = (side_reg > MAX_SIDE) ? MAX_SIDE : side_reg;
    rad = (reach_reg > MAX_REACH) ? MAX_REACH : reach_reg;
    fe_sum = ebase_reg + edge_total;
    b.first_edge = (fe_sum > gwnl_pkg::EDGE_MAX) ? gwnl_pkg::EDGE_MAX
                                                 : fe_sum[gwnl_pkg::FE_W-1:0];
    b.neighbor_index = '0;
    b.last = 1'b1;
    b.no_neighbor = 1'b0;
    b.bad_cell = 1'b0;
    b.src_cell = cell_idx;
    if (side == 0 || cell_idx >= side * side) begin
      b.bad_cell = 1'b1;
      queue_beat(b);
      return;
    end
    col = cell_idx % side;
    row = cell_idx / side;
    x0 = (col > rad) ? col - rad : 0;
    y0 = (row > rad) ? row - rad : 0;
    x1 = (col + rad + 1 < side) ? col + rad + 1 : side;
    y1 = (row + rad + 1 < side) ? row + rad + 1 : side;
    for (y = y0; y < y1; y++) begin
      for (x = x0; x < x1; x++) begin
        idx = y * side + x;
        if (idx != cell_idx) begin
          b.neighbor_index = gwnl_pkg::NB_W'(idx + ibase_reg);
          b.last = 1'b0;
          found.insert(found.size(), b);
        end
      end
    end
    // Lonely cell: reach zero or a one-cell grid
    if (found.size() == 0) begin
      b.neighbor_index = '0;
      b.last = 1'b1;
      b.no_neighbor = 1'b1;
      queue_beat(b);
      return;
    end
    found[found.size()-1].last = 1'b1;
    foreach (found[i]) queue_beat(found[i]);
    grown = edge_total + found.size();
    edge_total = (grown > gwnl_pkg::EDGE_MAX) ? gwnl_pkg::EDGE_MAX
                                              : grown[gwnl_pkg::FE_W-1:0];
  endfunction

  always @(posedge clk) begin
    nb_beat_t want;
    if (!rst_n) begin
      side_reg = gwnl_pkg::RST_GRID_SIDE;
      reach_reg = gwnl_pkg::RST_REACH;
      ibase_reg = '0;
      ebase_reg = '0;
      edge_total = '0;
      mismatch_count = 0;
      window_beats.delete();
    end else begin
      // Mirror register writes
      if (cfg_we) begin
        case (cfg_addr)
          gwnl_pkg::CFG_GRID_SIDE:  side_reg = cfg_wdata[gwnl_pkg::SIDE_W-1:0];
          gwnl_pkg::CFG_REACH:      reach_reg = cfg_wdata[gwnl_pkg::REACH_W-1:0];
          gwnl_pkg::CFG_INDEX_BASE: ibase_reg = cfg_wdata[gwnl_pkg::IBASE_W-1:0];
          gwnl_pkg::CFG_EDGE_BASE:  ebase_reg = cfg_wdata[gwnl_pkg::EBASE_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) list_window(in_mon.cell_index);
      // Compare each result beat with the oldest expectation
      if (out_mon.valid && out_mon.ready) begin
        if (window_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat neighbor_index %0d",
                                    out_mon.neighbor_index));
        end else begin
          want = window_beats.pop_front();
          if (out_mon.neighbor_index !== want.neighbor_index)
            report_mismatch($sformatf("cell %0d neighbor_index got %0d want %0d",
                                      want.src_cell, out_mon.neighbor_index,
                                      want.neighbor_index));
          if (out_mon.first_edge !== want.first_edge)
            report_mismatch($sformatf("cell %0d first_edge got %0d want %0d",
                                      want.src_cell, out_mon.first_edge, want.first_edge));
          if (out_mon.last !== want.last)
            report_mismatch($sformatf("cell %0d last got %b want %b",
                                      want.src_cell, out_mon.last, want.last));
          if (out_mon.no_neighbor !== want.no_neighbor)
            report_mismatch($sformatf("cell %0d no_neighbor got %b want %b",
                                      want.src_cell, out_mon.no_neighbor, want.no_neighbor));
          if (out_mon.bad_cell !== want.bad_cell)
            report_mismatch($sformatf("cell %0d bad_cell got %b want %b",
                                      want.src_cell, out_mon.bad_cell, want.bad_cell));
        end
      end
    end
    beats_owed <= window_beats.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps
module tb_top;

  logic                            clk;
  logic                            rst_n;
  logic                            cfg_we;
  logic [gwnl_pkg::CFG_ADDR_W-1:0] cfg_addr;
  logic [gwnl_pkg::CFG_DATA_W-1:0] cfg_wdata;
  int                              mismatch_total;
  int                              beats_owed;
  int                              send_idle;
  int                              recv_idle;
  int                              cells_sent;

  gwnl_in_if  in_ch ();
  gwnl_out_if out_ch ();

  grid_window_neighbor_lister_top u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  gwnl_neighbor_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_addr       (cfg_addr),
    .cfg_wdata      (cfg_wdata),
    .in_mon         (in_ch),
    .out_mon        (out_ch),
    .mismatch_count (mismatch_total),
    .beats_owed     (beats_owed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #4_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Randomly stall the result channel
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  // Write all four registers; wdata bits above each register are junk
  task automatic configure(input int unsigned side, input int unsigned rad,
                           input int unsigned ibase, input int unsigned ebase);
    logic [gwnl_pkg::CFG_DATA_W-1:0] w;
    w = gwnl_pkg::CFG_DATA_W'($urandom);
    w[gwnl_pkg::SIDE_W-1:0] = side[gwnl_pkg::SIDE_W-1:0];
    cfg_we <= 1'b1;
    cfg_addr <= gwnl_pkg::CFG_GRID_SIDE;
    cfg_wdata <= w;
    @(posedge clk);
    w = gwnl_pkg::CFG_DATA_W'($urandom);
    w[gwnl_pkg::REACH_W-1:0] = rad[gwnl_pkg::REACH_W-1:0];
    cfg_addr <= gwnl_pkg::CFG_REACH;
    cfg_wdata <= w;
    @(posedge clk);
    w = gwnl_pkg::CFG_DATA_W'($urandom);
    w[gwnl_pkg::IBASE_W-1:0] = ibase[gwnl_pkg::IBASE_W-1:0];
    cfg_addr <= gwnl_pkg::CFG_INDEX_BASE;
    cfg_wdata <= w;
    @(posedge clk);
    cfg_addr <= gwnl_pkg::CFG_EDGE_BASE;
    cfg_wdata <= ebase[gwnl_pkg::EBASE_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Offer one cell beat; valid stays high on return
  task automatic send_cell(input logic [gwnl_pkg::CELL_W-1:0] cell_idx);
    if (cells_sent < 40) begin
      send_idle = 36;
      recv_idle = 84;
    end else if (cells_sent < 82) begin
      send_idle = 84;
      recv_idle = 36;
    end else begin
      send_idle = 0;
      recv_idle = 0;
    end
    if ($urandom_range(0, 99) < send_idle) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < send_idle);
    end
    in_ch.valid <= 1'b1;
    in_ch.cell_index <= cell_idx;
    do @(posedge clk); while (!in_ch.ready);
    cells_sent++;
  endtask

  // Drop valid and hold until every expected beat has come back
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (beats_owed != 0) @(posedge clk);
  endtask

  initial begin
    int unsigned side, eff, row, col;
    int pick;
    logic [gwnl_pkg::CELL_W-1:0] cell_idx;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = '0;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.cell_index = '0;
    send_idle = 36;
    recv_idle = 84;
    cells_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset settings: one-cell grid, so lonely and bad cells
    send_cell(20'd0);
    send_cell(20'd1);
    send_cell(20'hFFFFF);
    drain();

    // Small grid: corners, border, center, first index past the end
    configure(5, 1, 0, 0);
    send_cell(20'd0);
    send_cell(20'd4);
    send_cell(20'd20);
    send_cell(20'd24);
    send_cell(20'd12);
    send_cell(20'd2);
    send_cell(20'd25);
    drain();

    // Oversized side clamps, widest window, largest bases
    configure(2047, 3, 24'hFFFFFF, 26'h3FFFFFF);
    send_cell(20'd0);
    send_cell(20'd1023);
    send_cell(20'hFFC00);
    send_cell(20'hFFFFF);
    send_cell(20'h5A5A5);
    send_cell(20'hA5A5A);
    drain();

    // Zero side: every cell is out of range
    configure(0, 0, 0, 0);
    send_cell(20'd0);
    send_cell(20'hFFFFF);
    drain();

    // Zero reach leaves every in-range cell lonely; cell 36 is out of range
    configure(6, 0, 24'h123456, 26'h2AAAAAA);
    send_cell(20'd0);
    send_cell(20'd35);
    send_cell(20'd36);
    drain();

    // One-cell grid with the widest window
    configure(1, 3, 24'h000777, 26'h1555555);
    send_cell(20'd0);
    drain();

    // Random settings, mostly in-range cells with a bias to the borders
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) begin
        side = $urandom_range(1024, 2047);
      end else begin
        case ($urandom_range(0, 5))
          0: side = $urandom_range(1000, 2047);
          1: side = $urandom_range(1, 4);
          5: side = $urandom_range(0, 2047);
          default: side = $urandom_range(5, 48);
        endcase
      end
      configure(side, $urandom_range(0, 3),
                ($urandom_range(0, 3) == 0) ? 24'hFFFFFF : $urandom,
                $urandom);
      eff = (side > gwnl_pkg::DEF_MAX_SIDE) ? gwnl_pkg::DEF_MAX_SIDE : side;
      for (int k = 0; k < 13; k++) begin
        pick = $urandom_range(0, 99);
        if (eff == 0 || pick < 12) begin
          if (pick < 6 && eff * eff + 3 < (1 << gwnl_pkg::CELL_W))
            cell_idx = gwnl_pkg::CELL_W'(eff * eff + $urandom_range(0, 3));
          else
            cell_idx = gwnl_pkg::CELL_W'($urandom);
        end else if (pick < 40) begin
          row = $urandom_range(0, 1) ? 0 : eff - 1;
          col = $urandom_range(0, eff - 1);
          cell_idx = $urandom_range(0, 1) ? gwnl_pkg::CELL_W'(row * eff + col)
                                          : gwnl_pkg::CELL_W'(col * eff + row);
        end else begin
          cell_idx = gwnl_pkg::CELL_W'($urandom_range(0, eff * eff - 1));
        end
        send_cell(cell_idx);
        // Let the block run dry once in mid stream
        if (ph == 2 && k == 8) drain();
      end
      drain();
    end

    repeat (60) @(posedge clk);
    if (mismatch_total == 0 && beats_owed == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+rtl
rtl/gwnl_pkg.sv
rtl/gwnl_if.sv
rtl/gwnl_ctrl.sv
rtl/gwnl_dp.sv
rtl/grid_window_neighbor_lister_top.sv
tb/gwnl_neighbor_checker.sv
tb/tb_top.sv
